### rtl/band_power_calibration_defines.svh
// Assertion macros shared by the band power calibration RTL.
`ifndef BAND_POWER_CALIBRATION_DEFINES_SVH
`define BAND_POWER_CALIBRATION_DEFINES_SVH

// Same-cycle implication, checked on clk, off during rst.
`define BPC_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off during rst.
`define BPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must never hold.
`define BPC_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

### rtl/bpc_pkg.sv
// Shared types, constants and calibration tables for the band power calibration block.
package bpc_pkg;

  localparam int BAND_TOTAL = 10;
  localparam int BAND_W     = 4;
  localparam int READ_W     = 12;
  localparam int FREQ_W     = 16;
  localparam int WATT_W     = 18;

  localparam int LANES    = 2;
  localparam int LANE_FWD = 0;
  localparam int LANE_REV = 1;

  localparam logic [BAND_W-1:0] DEFAULT_BAND = 4'd4;

  localparam int QUEUE_DEPTH = 2;

  // Coefficient widths, units of 1e-10 W.
  localparam int COEF_A_W = 19;
  localparam int COEF_B_W = 28;
  localparam int COEF_C_W = 35;

  // Datapath widths.
  localparam int SQ_W        = 2 * READ_W;
  localparam int AX_W        = COEF_A_W + SQ_W;
  localparam int BX_W        = COEF_B_W + READ_W;
  localparam int POLY_W      = AX_W + 2;
  localparam int SCALED_W    = POLY_W - 3;
  localparam int TRUNC_SHIFT = 10;
  localparam int TRUNC_W     = SCALED_W - TRUNC_SHIFT;
  localparam int RECIP_W     = 32;
  localparam int PROD_W      = TRUNC_W + RECIP_W;
  localparam int RECIP_SHIFT = 45;
  localparam int QUOT_W      = 19;
  localparam int DIV_W       = 24;
  localparam int QD_W        = QUOT_W + DIV_W;

  // q = round(p * 256 / 1e10) = floor((p + 19531250) / 4 / 5^10)
  localparam logic [POLY_W-1:0]  ROUND_BIAS = 45'd19531250;
  localparam logic [DIV_W-1:0]   DIVISOR    = 24'd9765625;
  localparam logic [RECIP_W-1:0] RECIP      = 32'd3689348814;  // floor(2^55 / 5^10)
  localparam logic [WATT_W-1:0]  SAT_MAX    = 18'h3FFFF;

  typedef struct packed {
    logic [BAND_W-1:0] band;
    logic [READ_W-1:0] fwd;
    logic [READ_W-1:0] rev;
  } bpc_item_t;

  localparam logic [FREQ_W-1:0] CENTRE [BAND_TOTAL] = '{
    16'd1800, 16'd3500, 16'd7000, 16'd10100, 16'd14000,
    16'd18068, 16'd21000, 16'd24890, 16'd28000, 16'd50000
  };

  localparam logic [COEF_A_W-1:0] COEF_A [LANES][BAND_TOTAL] = '{
    '{19'd344790, 19'd240674, 19'd232939, 19'd246085, 19'd236828,
      19'd248176, 19'd243053, 19'd244645, 19'd242895, 19'd259059},
    '{19'd74220, 19'd57110, 19'd54630, 19'd57766, 19'd59187,
      19'd57382, 19'd57965, 19'd60771, 19'd65335, 19'd92993}
  };

  localparam logic [COEF_B_W-1:0] COEF_B [LANES][BAND_TOTAL] = '{
    '{28'd122427720, 28'd144357467, 28'd121373473, 28'd107465893, 28'd145613211,
      28'd134516666, 28'd138282772, 28'd146616079, 28'd132563180, 28'd145094203},
    '{28'd43297273, 28'd39180843, 28'd38557671, 28'd39250007, 28'd39376254,
      28'd40787178, 28'd41264494, 28'd42045813, 28'd42116160, 28'd66398257}
  };

  localparam logic signed [COEF_C_W-1:0] COEF_C [LANES][BAND_TOTAL] = '{
    '{-35'sd5888886198, -35'sd10384081397, -35'sd6636951614, -35'sd3731147554,
      -35'sd9381904235, -35'sd7756303431, -35'sd8784256700, -35'sd10958326768,
      -35'sd6386329677, -35'sd6225379768},
    '{35'sd418036189, 35'sd347077466, 35'sd336771535, 35'sd378529411,
      35'sd422536579, 35'sd389703097, 35'sd384298887, 35'sd442086157,
      35'sd441096503, 35'sd677537797}
  };

  function automatic logic [COEF_A_W-1:0] coef_a(input int lane,
                                                 input logic [BAND_W-1:0] band);
    logic [COEF_A_W-1:0] v;
    v = '0;
    if (band < BAND_TOTAL) v = COEF_A[lane][band];
    return v;
  endfunction

  function automatic logic [COEF_B_W-1:0] coef_b(input int lane,
                                                 input logic [BAND_W-1:0] band);
    logic [COEF_B_W-1:0] v;
    v = '0;
    if (band < BAND_TOTAL) v = COEF_B[lane][band];
    return v;
  endfunction

  function automatic logic signed [COEF_C_W-1:0] coef_c(input int lane,
                                                        input logic [BAND_W-1:0] band);
    logic signed [COEF_C_W-1:0] v;
    v = '0;
    if (band < BAND_TOTAL) v = COEF_C[lane][band];
    return v;
  endfunction

endpackage

### rtl/bpc_front.sv
// Front end: accepts readings, masks them and picks the calibration band.
module bpc_front #(
  parameter int BAND_COUNT   = 10,
  parameter int READING_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [bpc_pkg::READ_W-1:0] forward_reading,
  input  logic [bpc_pkg::READ_W-1:0] reverse_reading,
  input  logic [bpc_pkg::FREQ_W-1:0] frequency_khz,
  output logic                       push_valid,
  input  logic                       push_ready,
  output bpc_pkg::bpc_item_t         push_item
);
  import bpc_pkg::*;

  localparam int NB   = (BAND_COUNT < BAND_TOTAL) ? BAND_COUNT : BAND_TOTAL;
  localparam int NMID = NB - 1;
  localparam int XW   = (READING_BITS < READ_W) ? READING_BITS : READ_W;
  localparam logic [READ_W-1:0] READ_MASK = READ_W'((1 << XW) - 1);

  logic              held;
  logic              accept;
  logic [NMID-1:0]   above_mid;
  logic [BAND_W-1:0] band_sel;

  // Tie goes up: f >= ceil((c[i] + c[i+1]) / 2).
  for (genvar i = 0; i < NMID; i++) begin : g_mid
    localparam logic [FREQ_W:0] MID =
      ((FREQ_W+1)'(CENTRE[i]) + (FREQ_W+1)'(CENTRE[i+1]) + (FREQ_W+1)'(1)) >> 1;
    assign above_mid[i] = ({1'b0, frequency_khz} >= MID);
  end

  always_comb begin
    if (frequency_khz >= CENTRE[NB-1]) begin
      band_sel = DEFAULT_BAND;
    end else begin
      band_sel = BAND_W'($countones(above_mid));
    end
  end

  assign busy       = held && !push_ready;
  assign accept     = start && !busy;
  assign push_valid = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (push_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      push_item.band <= band_sel;
      push_item.fwd  <= forward_reading & READ_MASK;
      push_item.rev  <= reverse_reading & READ_MASK;
    end
  end

endmodule

### rtl/bpc_queue.sv
// Short FIFO between the band select front end and the calibration pipeline.
`include "band_power_calibration_defines.svh"

module bpc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  bpc_pkg::bpc_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output bpc_pkg::bpc_item_t pop_item
);
  import bpc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  bpc_item_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slots[rptr];

  // Depth is a power of two, pointers wrap on their own.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + PTR_W'(1);
      if (pop)  rptr <= rptr + PTR_W'(1);
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_item;
  end

  `BPC_ASSERT_NEXT(q_fill, push && !pop, count == $past(count) + CNT_W'(1), "queue fill count off")
  `BPC_ASSERT_NEXT(q_drain, pop && !push, count == $past(count) - CNT_W'(1), "queue drain count off")

endmodule

### rtl/bpc_back.sv
// Calibration pipeline: quadratic per lane, rounding by reciprocal, clamp and saturate.
`include "band_power_calibration_defines.svh"

module bpc_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bpc_pkg::bpc_item_t         in_item,
  output logic                       done,
  output logic [bpc_pkg::WATT_W-1:0] forward_watts,
  output logic [bpc_pkg::WATT_W-1:0] reverse_watts,
  output logic [bpc_pkg::BAND_W-1:0] band_index
);
  import bpc_pkg::*;

  localparam int STAGES = 7;

  logic [STAGES-1:0] vld;
  logic [BAND_W-1:0] band_pipe [STAGES];

  logic [READ_W-1:0]          xin   [LANES];
  logic [SQ_W-1:0]            xsq1  [LANES];
  logic [BX_W-1:0]            bx1   [LANES];
  logic [COEF_A_W-1:0]        a1    [LANES];
  logic signed [COEF_C_W-1:0] c1    [LANES];
  logic [AX_W-1:0]            ax2   [LANES];
  logic [BX_W-1:0]            bx2   [LANES];
  logic signed [COEF_C_W-1:0] c2    [LANES];
  logic signed [POLY_W-1:0]   p3    [LANES];
  logic                       pos4  [LANES];
  logic [SCALED_W-1:0]        m4    [LANES];
  logic                       pos5  [LANES];
  logic [SCALED_W-1:0]        m5    [LANES];
  logic [QUOT_W-1:0]          q5    [LANES];
  logic                       pos6  [LANES];
  logic [SCALED_W-1:0]        m6    [LANES];
  logic [QUOT_W-1:0]          q6    [LANES];
  logic [QD_W-1:0]            qd6   [LANES];
  logic [WATT_W-1:0]          watts [LANES];

  // Pipeline never stalls: the receiver takes every result.
  assign in_ready = 1'b1;

  assign xin[LANE_FWD] = in_item.fwd;
  assign xin[LANE_REV] = in_item.rev;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    band_pipe[0] <= in_item.band;
    for (int s = 1; s < STAGES; s++) band_pipe[s] <= band_pipe[s-1];
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [POLY_W-1:0] biased;
    logic [PROD_W-1:0] prod;
    logic [QD_W-1:0]   rem;
    logic [QUOT_W:0]   qfix;

    assign biased = $unsigned(p3[l]) + ROUND_BIAS;
    assign prod   = PROD_W'(m4[l][SCALED_W-1:TRUNC_SHIFT]) * PROD_W'(RECIP);
    assign rem    = QD_W'(m6[l]) - qd6[l];
    // Estimate is low by at most one.
    assign qfix   = (QUOT_W+1)'(q6[l]) + (QUOT_W+1)'(rem >= QD_W'(DIVISOR));

    always_ff @(posedge clk) begin
      // coefficient fetch, x^2 and B*x
      xsq1[l] <= SQ_W'(xin[l]) * SQ_W'(xin[l]);
      bx1[l]  <= BX_W'(coef_b(l, in_item.band)) * BX_W'(xin[l]);
      a1[l]   <= coef_a(l, in_item.band);
      c1[l]   <= coef_c(l, in_item.band);
      // A*x^2
      ax2[l]  <= AX_W'(a1[l]) * AX_W'(xsq1[l]);
      bx2[l]  <= bx1[l];
      c2[l]   <= c1[l];
      // sum of terms, 1e-10 W
      p3[l]   <= $signed({2'b00, ax2[l]}) + $signed({5'b00000, bx2[l]}) + POLY_W'(c2[l]);
      // positive check and rounding bias, drop the factor of four
      pos4[l] <= !p3[l][POLY_W-1] && (p3[l] != '0);
      m4[l]   <= biased[SCALED_W+1:2];
      // quotient estimate by reciprocal of 5^10
      pos5[l] <= pos4[l];
      m5[l]   <= m4[l];
      q5[l]   <= prod[RECIP_SHIFT +: QUOT_W];
      // back-multiply for correction
      pos6[l] <= pos5[l];
      m6[l]   <= m5[l];
      q6[l]   <= q5[l];
      qd6[l]  <= QD_W'(q5[l]) * QD_W'(DIVISOR);
      // correct, clamp at zero, saturate
      if (!pos6[l]) begin
        watts[l] <= '0;
      end else if (qfix > (QUOT_W+1)'(SAT_MAX)) begin
        watts[l] <= SAT_MAX;
      end else begin
        watts[l] <= qfix[WATT_W-1:0];
      end
    end
  end

  assign done          = vld[STAGES-1];
  assign band_index    = band_pipe[STAGES-1];
  assign forward_watts = watts[LANE_FWD];
  assign reverse_watts = watts[LANE_REV];

  `BPC_ASSERT_NEXT(back_clamp_fwd, vld[STAGES-2] && !pos6[LANE_FWD], forward_watts == '0, "forward not clamped")
  `BPC_ASSERT_NEXT(back_clamp_rev, vld[STAGES-2] && !pos6[LANE_REV], reverse_watts == '0, "reverse not clamped")

endmodule

### rtl/band_power_calibration.sv
// Top level of the band power calibration block.
//
// One forward/reverse reading pair and a frequency in kHz go in per transfer
// (start high while busy is low); one calibrated result comes out per input,
// marked by a one-cycle done strobe, in input order. The receiver cannot
// stall: results must be taken the cycle they appear. A new pair is taken
// every clock cycle; busy only rises if the queue between the band selector
// and the calibration pipeline fills, which the free-running pipeline never
// lets happen. Each pair passes the front register loaded at the transfer,
// then the queue slot that follows it, then the seven pipeline stages of
// the calibration path: x^2 and B*x, A*x^2, term sum,
// rounding bias, a 32x32 reciprocal multiply for the divide by the Q10.8
// scale, a back-multiply and a one-step quotient correction. The block keeps
// no state between items and needs no clearing after reset.
//
// Band select: nearest of the band centers, ties to the upper band, 50000 kHz
// and above (or at or above the last used center) go to band 4. Outputs are
// unsigned Q10.8 watts, negative polynomial results clamp to zero, saturated
// at full scale. Reading bits above READING_BITS are ignored; BAND_COUNT
// limits how many centers take part in the search.
`include "band_power_calibration_defines.svh"

module band_power_calibration #(
  parameter int BAND_COUNT   = 10,
  parameter int READING_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [bpc_pkg::READ_W-1:0] forward_reading,
  input  logic [bpc_pkg::READ_W-1:0] reverse_reading,
  input  logic [bpc_pkg::FREQ_W-1:0] frequency_khz,
  output logic                       done,
  output logic [bpc_pkg::WATT_W-1:0] forward_watts,
  output logic [bpc_pkg::WATT_W-1:0] reverse_watts,
  output logic [bpc_pkg::BAND_W-1:0] band_index
);
  import bpc_pkg::*;

  // front -> queue
  logic      push_valid;
  logic      push_ready;
  bpc_item_t push_item;
  // queue -> calibration pipeline
  logic      pop_valid;
  logic      pop_ready;
  bpc_item_t pop_item;

  bpc_front #(
    .BAND_COUNT  (BAND_COUNT),
    .READING_BITS(READING_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .forward_reading(forward_reading),
    .reverse_reading(reverse_reading),
    .frequency_khz  (frequency_khz),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_item      (push_item)
  );

  bpc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item)
  );

  bpc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (pop_valid),
    .in_ready     (pop_ready),
    .in_item      (pop_item),
    .done         (done),
    .forward_watts(forward_watts),
    .reverse_watts(reverse_watts),
    .band_index   (band_index)
  );

  // Every delivered band must be a real table row.
  `BPC_ASSERT_IMPLIES(top_band_range, done, band_index < BAND_W'(BAND_TOTAL), "band index out of range")

endmodule
